// File: sv/circular_deque_unit_assert.svh
// assertion macros for the circular deque unit
// used by the top level only; expects clk and rst_n in scope
`ifndef CIRCULAR_DEQUE_UNIT_ASSERT_SVH
`define CIRCULAR_DEQUE_UNIT_ASSERT_SVH

// same-cycle check, held off during reset
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check, held off during reset
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cdq_pkg.sv
// shared types and constants for the circular deque unit
// no dependencies
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DEPTH    = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_QUERY      = 3'd4
  } cdq_mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_in;   // push front: whole row moves one cell back
    logic shift_out;  // pop front: whole row moves one cell forward
    logic append;     // push back: first empty cell takes the new value
    logic trim;       // pop back: last occupied cell drops its entry
  } cdq_cell_ctl_t;

  // one result beat
  typedef struct packed {
    logic [DATA_W-1:0]   popped_value;
    cdq_status_t         status;
    logic [CNT_W-1:0]    fill_count;
    logic [DATA_W-1:0]   front_value;
    logic [DATA_W-1:0]   back_value;
  } cdq_result_t;

endpackage

// File: sv/circular_deque_unit.sv
// Circular deque unit: a double-ended queue of DEPTH words kept in a row of
// cells, front entry always in cell 0. One operation is taken per clock unless
// the input stalls; its result beat is registered on acceptance. Pushes and
// pops at the front shift the whole cell row by one in that cycle, back
// operations touch only the cell at the fill boundary. A two-entry result
// buffer lets input flow on while one result waits; the input stalls only when
// both result entries are held. No clearing pass is needed after reset.
// depends on cdq_pkg, cdq_cell, cdq_out_buf, circular_deque_unit_assert.svh
`timescale 1ns / 1ps
`include "circular_deque_unit_assert.svh"

module circular_deque_unit import cdq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [DATA_W-1:0]    in_data_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_popped_value,
  output logic [STATUS_W-1:0]  out_status,
  output logic [CNT_W-1:0]     out_fill_count,
  output logic [DATA_W-1:0]    out_front_value,
  output logic [DATA_W-1:0]    out_back_value
);

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_data_nxt [DEPTH];
  logic [DEPTH-1:0]  occ;
  logic [DEPTH-1:0]  occ_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              accept;
  logic              buf_full;
  logic              is_full;
  logic              is_empty;
  logic              want_push;
  logic              want_pop;
  cdq_cell_ctl_t     ctl;
  cdq_status_t       status;
  logic [DATA_W-1:0] popped;
  logic [DATA_W-1:0] back_now;
  logic [DATA_W-1:0] back_nxt;
  cdq_result_t       res;
  cdq_result_t       out_res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = buf_full;
  assign is_full  = occ[DEPTH-1];
  assign is_empty = !occ[0];

  // decode the operation into cell commands
  always_comb begin
    ctl       = '0;
    want_push = 1'b0;
    want_pop  = 1'b0;
    unique case (in_mode)
      MODE_PUSH_BACK: begin
        want_push  = 1'b1;
        ctl.append = accept && !is_full;
      end
      MODE_PUSH_FRONT: begin
        want_push    = 1'b1;
        ctl.shift_in = accept && !is_full;
      end
      MODE_POP_FRONT: begin
        want_pop      = 1'b1;
        ctl.shift_out = accept && !is_empty;
      end
      MODE_POP_BACK: begin
        want_pop = 1'b1;
        ctl.trim = accept && !is_empty;
      end
      default: begin
      end
    endcase
  end

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] l_data;
    logic              l_occ;
    logic [DATA_W-1:0] r_data;
    logic              r_occ;

    if (i == 0) begin : g_head
      assign l_data = in_data_in;
      assign l_occ  = 1'b1;
    end else begin : g_mid_l
      assign l_data = cell_data[i-1];
      assign l_occ  = occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_data = '0;
      assign r_occ  = 1'b0;
    end else begin : g_mid_r
      assign r_data = cell_data[i+1];
      assign r_occ  = occ[i+1];
    end

    cdq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_data   (in_data_in),
      .left_data  (l_data),
      .left_occ   (l_occ),
      .right_data (r_data),
      .right_occ  (r_occ),
      .data_r     (cell_data[i]),
      .occ_r      (occ[i]),
      .data_nxt   (cell_data_nxt[i]),
      .occ_nxt    (occ_nxt[i])
    );
  end

  // back entry now and after the update: the last occupied cell
  always_comb begin
    back_now = '0;
    back_nxt = '0;
    for (int i = 0; i < DEPTH - 1; i++) begin
      back_now = back_now | (cell_data[i] & {DATA_W{occ[i] && !occ[i+1]}});
      back_nxt = back_nxt | (cell_data_nxt[i] & {DATA_W{occ_nxt[i] && !occ_nxt[i+1]}});
    end
    back_now = back_now | (cell_data[DEPTH-1] & {DATA_W{occ[DEPTH-1]}});
    back_nxt = back_nxt | (cell_data_nxt[DEPTH-1] & {DATA_W{occ_nxt[DEPTH-1]}});
  end

  // status, popped word and count
  always_comb begin
    status    = ST_OK;
    popped    = '0;
    count_nxt = count_r;
    priority if (want_push && is_full) begin
      status = ST_FULL;
    end else if (want_pop && is_empty) begin
      status = ST_EMPTY;
    end else if (ctl.shift_out) begin
      popped    = cell_data[0];
      count_nxt = count_r - CNT_W'(1);
    end else if (ctl.trim) begin
      popped    = back_now;
      count_nxt = count_r - CNT_W'(1);
    end else if (ctl.shift_in || ctl.append) begin
      count_nxt = count_r + CNT_W'(1);
    end else begin
      // query, spare mode or idle cycle: count holds
      count_nxt = count_r;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result beat
  always_comb begin
    res.popped_value = popped;
    res.status       = status;
    res.fill_count   = count_nxt;
    res.front_value  = occ_nxt[0] ? cell_data_nxt[0] : '0;
    res.back_value   = back_nxt;
  end

  cdq_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (accept),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_popped_value = out_res.popped_value;
  assign out_status       = out_res.status;
  assign out_fill_count   = out_res.fill_count;
  assign out_front_value  = out_res.front_value;
  assign out_back_value   = out_res.back_value;

  // checks
  `CDQ_ASSERT_NOW(a_count_matches, 1'b1, count_r == CNT_W'($countones(occ)), "count mismatch")
  `CDQ_ASSERT_NOW(a_occ_packed, 1'b1, (occ & (occ + DEPTH'(1))) == '0, "occupancy has a gap")
  `CDQ_ASSERT_NEXT(a_full_push_holds, accept && want_push && is_full, $stable(count_r) && $stable(occ), "push to full changed state")
  `CDQ_ASSERT_NOW(a_skid_needs_main, in_stall, out_valid, "skid held without output")

endmodule

// File: sv/cdq_cell.sv
// one storage cell of the deque row: a data word and an occupied flag
// depends on cdq_pkg
`timescale 1ns / 1ps

module cdq_cell import cdq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cdq_cell_ctl_t       ctl,
  input  logic [DATA_W-1:0]   new_data,
  input  logic [DATA_W-1:0]   left_data,
  input  logic                left_occ,
  input  logic [DATA_W-1:0]   right_data,
  input  logic                right_occ,
  output logic [DATA_W-1:0]   data_r,
  output logic                occ_r,
  output logic [DATA_W-1:0]   data_nxt,
  output logic                occ_nxt
);

  // next contents from the command and the neighbors
  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    priority if (ctl.shift_in) begin
      data_nxt = left_data;
      occ_nxt  = left_occ;
    end else if (ctl.shift_out) begin
      data_nxt = right_data;
      occ_nxt  = right_occ;
    end else if (ctl.append && !occ_r && left_occ) begin
      data_nxt = new_data;
      occ_nxt  = 1'b1;
    end else if (ctl.trim && occ_r && !right_occ) begin
      occ_nxt  = 1'b0;
    end else begin
      // cell keeps its contents
      occ_nxt  = occ_r;
    end
  end

  // occupied flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // data word, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: sv/cdq_out_buf.sv
// two-entry result buffer: output register plus skid register
// depends on cdq_pkg
`timescale 1ns / 1ps

module cdq_out_buf import cdq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  cdq_result_t   res,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output cdq_result_t   out_res
);

  logic        main_valid_r;
  logic        skid_valid_r;
  cdq_result_t main_r;
  cdq_result_t skid_r;
  logic        take;

  assign take      = main_valid_r && !out_stall;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;
  assign full      = skid_valid_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!main_valid_r || take) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (res_valid) begin
      if (!main_valid_r || take) begin
        main_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

endmodule
